// File: rtl/ssr_pkg.sv
// shared types and constants for the sum of subarray ranges block
// no dependencies
package ssr_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int VAL_W       = 32;
  localparam int TOTAL_W     = 52;

  // one queued request: sample, end-of-sequence mark, past-length mark
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    drop;
  } ssr_item_t;

endpackage

// File: rtl/ssr_front.sv
// front end: accepts requests, counts sequence length, marks requests past the limit
// depends on ssr_pkg
module ssr_front
  import ssr_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_sample_value,
  input  logic                    in_is_last,
  input  logic                    q_full,
  output logic                    q_push,
  output ssr_item_t               q_item
);

  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] seen_r, seen_nxt;
  logic          drop;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign drop     = (seen_r == CW'(MAX_LEN));

  assign q_item.value = in_sample_value;
  assign q_item.last  = in_is_last;
  assign q_item.drop  = drop;

  always_comb begin
    seen_nxt = seen_r;
    if (q_push) begin
      if (in_is_last) seen_nxt = '0;
      else if (!drop) seen_nxt = seen_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) seen_r <= '0;
    else        seen_r <= seen_nxt;
  end

endmodule

// File: rtl/ssr_queue.sv
// two-entry request queue between front and back end
// depends on ssr_pkg
module ssr_queue
  import ssr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ssr_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output ssr_item_t head
);

  ssr_item_t   slot_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: rtl/ssr_back.sv
// back end: monotonic max and min stacks in memory, running sums, accumulator, result register
// depends on ssr_pkg
module ssr_back
  import ssr_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  ssr_item_t          q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TOTAL_W-1:0] out_range_total,
  output logic               out_too_long
);

  localparam int CW    = $clog2(MAX_LEN + 1);
  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SUM_W = VAL_W + 1 + CW;
  localparam int ACC_W = SUM_W + CW;
  localparam int SAT_W = (ACC_W > TOTAL_W) ? ACC_W : TOTAL_W + 1;
  localparam int EW    = VAL_W + CW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_CMP, ST_SUB, ST_PUSH, ST_ADD, ST_DIFF, ST_OUT
  } state_t;

  state_t                   state_r;
  logic                     side_r;    // 0 max stack, 1 min stack
  logic signed [VAL_W-1:0]  x_r;
  logic                     last_r;
  logic [CW-1:0]            c_r;
  logic [CW-1:0]            tmax_r, tmin_r;
  logic signed [SUM_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]  smax_r, smin_r;
  logic [ACC_W-1:0]         acc_r;
  logic                     ovf_r;
  logic                     out_valid_r;
  logic [TOTAL_W-1:0]       total_r;
  logic                     too_long_r;

  logic [EW-1:0]            mem_max [MAX_LEN];
  logic [EW-1:0]            mem_min [MAX_LEN];
  logic [EW-1:0]            rmax_r, rmin_r;

  logic [CW-1:0]            top;
  logic [EW-1:0]            rd;
  logic signed [VAL_W-1:0]  rd_val;
  logic [CW-1:0]            rd_cnt;
  logic                     pops;
  logic signed [SUM_W:0]    diff;
  logic [SAT_W-1:0]         acc_ext;
  logic [TOTAL_W-1:0]       total_sat;
  logic                     emit;

  assign top    = side_r ? tmin_r : tmax_r;
  assign rd     = side_r ? rmin_r : rmax_r;
  assign rd_val = rd[EW-1:CW];
  assign rd_cnt = rd[CW-1:0];
  assign pops   = side_r ? (rd_val >= x_r) : (rd_val <= x_r);
  assign diff   = {smax_r[SUM_W-1], smax_r} - {smin_r[SUM_W-1], smin_r};
  assign acc_ext   = SAT_W'(acc_r);
  assign total_sat = (acc_ext > SAT_W'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}}
                                                         : acc_ext[TOTAL_W-1:0];
  assign emit  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign q_pop = (state_r == ST_IDLE) && q_not_empty;

  assign out_valid       = out_valid_r;
  assign out_range_total = total_r;
  assign out_too_long    = too_long_r;

  // stack memories: top entry read every cycle, written on push
  always_ff @(posedge clk) begin
    rmax_r <= mem_max[AW'(tmax_r - 1'b1)];
    rmin_r <= mem_min[AW'(tmin_r - 1'b1)];
    if (state_r == ST_PUSH && top < CW'(MAX_LEN)) begin
      if (side_r) mem_min[AW'(tmin_r)] <= {x_r, c_r};
      else        mem_max[AW'(tmax_r)] <= {x_r, c_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_r      <= 1'b0;
      tmax_r      <= '0;
      tmin_r      <= '0;
      smax_r      <= '0;
      smin_r      <= '0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!emit && out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            x_r    <= q_head.value;
            last_r <= q_head.last;
            side_r <= 1'b0;
            c_r    <= CW'(1);
            if (q_head.drop) begin
              ovf_r   <= 1'b1;
              state_r <= q_head.last ? ST_OUT : ST_IDLE;
            end else begin
              state_r <= ST_RD;
            end
          end
        end
        ST_RD: begin
          // wait for the registered top-of-stack read
          state_r <= (top == '0) ? ST_PUSH : ST_CMP;
        end
        ST_CMP: begin
          if (pops) begin
            if (side_r) tmin_r <= tmin_r - 1'b1;
            else        tmax_r <= tmax_r - 1'b1;
            prod_r  <= SUM_W'(rd_val) * SUM_W'($signed({1'b0, rd_cnt}));
            c_r     <= c_r + rd_cnt;
            state_r <= ST_SUB;
          end else begin
            state_r <= ST_PUSH;
          end
        end
        ST_SUB: begin
          if (side_r) smin_r <= smin_r - prod_r;
          else        smax_r <= smax_r - prod_r;
          state_r <= ST_RD;
        end
        ST_PUSH: begin
          if (top < CW'(MAX_LEN)) begin
            if (side_r) tmin_r <= tmin_r + 1'b1;
            else        tmax_r <= tmax_r + 1'b1;
          end
          prod_r  <= SUM_W'(x_r) * SUM_W'($signed({1'b0, c_r}));
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          if (side_r) begin
            smin_r  <= smin_r + prod_r;
            state_r <= ST_DIFF;
          end else begin
            smax_r  <= smax_r + prod_r;
            side_r  <= 1'b1;
            c_r     <= CW'(1);
            state_r <= ST_RD;
          end
        end
        ST_DIFF: begin
          if (diff > 0) acc_r <= acc_r + ACC_W'(diff);
          state_r <= last_r ? ST_OUT : ST_IDLE;
        end
        ST_OUT: begin
          if (emit) begin
            out_valid_r <= 1'b1;
            total_r     <= total_sat;
            too_long_r  <= ovf_r;
            tmax_r      <= '0;
            tmin_r      <= '0;
            smax_r      <= '0;
            smin_r      <= '0;
            acc_r       <= '0;
            ovf_r       <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/sum_of_subarray_ranges_core.sv
// sum of subarray ranges: front end, two-entry request queue, stack-machine back end
// flow: the back end takes one item at a time from the queue, only while idle; for each stack it
// reads the top, compares, pops with a subtract per popped entry, then pushes and adds; the sum
// difference then goes to the accumulator, and a last item on to the result register; pops are bounded by pushes
// reset: synchronous active-low rst_n clears stacks tops, sums, counters and result valid
// depends on ssr_pkg, ssr_front, ssr_queue, ssr_back
module sum_of_subarray_ranges_core
  import ssr_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_sample_value,
  input  logic                    in_is_last,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TOTAL_W-1:0]      out_range_total,
  output logic                    out_too_long
);

  logic      q_full, q_push, q_pop, q_not_empty;
  ssr_item_t q_item, q_head;

  ssr_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample_value, .in_is_last,
    .q_full, .q_push, .q_item
  );

  ssr_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_item(q_item), .full(q_full),
    .pop(q_pop), .not_empty(q_not_empty), .head(q_head)
  );

  ssr_back #(.MAX_LEN(MAX_LEN)) u_back (
    .clk, .rst_n, .q_not_empty, .q_head, .q_pop,
    .out_valid, .out_ready, .out_range_total, .out_too_long
  );

endmodule

// File: rtl/ssr_checker.sv
// port-level checks for sum_of_subarray_ranges_core, attached by bind
// depends on ssr_pkg
module ssr_checker
  import ssr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [TOTAL_W-1:0] out_range_total,
  input logic               out_too_long
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_range_total)
                                && $stable(out_too_long))
    else $error("result changed under stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a result needs at least an accept and several back end cycles
  a_lat: assert property (@(posedge clk)
    $rose(out_valid) |-> $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3))
    else $error("result too soon after reset");

  // queue empty after reset, so ready comes up the next cycle
  a_rdy: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("not ready after reset");

endmodule

bind sum_of_subarray_ranges_core ssr_checker u_ssr_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_range_total, .out_too_long
);
